>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLKD(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> design/mcls_pkg.sv
// ----------------------------------------------------------------------------
// mcls_pkg
// Shared types and fixed constants of the masked categorical label sampler.
// ----------------------------------------------------------------------------
package mcls_pkg;

    // Fixed field widths.
    localparam int LABEL_BITS = 8;
    localparam int UNI_BITS   = 16;
    localparam int INV_BITS   = 17;

    // 1.0 in unsigned Q1.16.
    localparam logic [INV_BITS-1:0] INV_ONE = 17'h10000;

    // Control broadcast to every storage cell.
    typedef struct packed {
        logic load;   // write the cell whose index matches
        logic shift;  // cells take the next cell's weight, the tail zero
    } t_cell_ctl;

    // Control of the scan accumulator.
    typedef struct packed {
        logic start;  // clear the running sum and index
        logic step;   // add the head weight and advance
    } t_scan_ctl;

endpackage

>>> design/mcls_cell.sv
// ----------------------------------------------------------------------------
// mcls_cell
// One weight slot of the storage chain. It is written by index while a row is
// loaded and hands its weight towards the head of the chain during the scan.
// ----------------------------------------------------------------------------
module mcls_cell #(
    parameter int WEIGHT_BITS = 16,
    parameter int CNT_W       = 4,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  mcls_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_W-1:0]       i_wr_idx,
    input  logic [WEIGHT_BITS-1:0] i_wr_data,
    input  logic [WEIGHT_BITS-1:0] i_nb_data,
    output logic [WEIGHT_BITS-1:0] o_data
);

    logic [WEIGHT_BITS-1:0] r_weight;

    // Indexed write has priority over the shift; both never coincide.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_wr_idx == CNT_W'(IDX))) begin
            r_weight <= i_wr_data;
        end else if (i_ctl.shift) begin
            r_weight <= i_nb_data;
        end
    end

    assign o_data = r_weight;

endmodule

>>> design/mcls_scan.sv
// ----------------------------------------------------------------------------
// mcls_scan
// Running-sum accumulator at the head of the chain. It adds one weight per
// cycle and flags the first index whose sum reaches the threshold.
// ----------------------------------------------------------------------------
module mcls_scan #(
    parameter int WEIGHT_BITS = 16,
    parameter int TOT_W       = 20,
    parameter int CNT_W       = 4,
    parameter int CHOSEN_W    = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mcls_pkg::t_scan_ctl                  i_ctl,
    input  logic [WEIGHT_BITS-1:0]               i_head,
    input  logic [TOT_W+mcls_pkg::UNI_BITS-1:0]  i_threshold,
    input  logic [CNT_W-1:0]                     i_last_idx,
    output logic                                 o_hit,
    output logic [CHOSEN_W-1:0]                  o_pick
);

    localparam int THR_W = TOT_W + mcls_pkg::UNI_BITS;

    logic [TOT_W-1:0] r_acm;
    logic [TOT_W-1:0] n_acm;
    logic [CNT_W-1:0] r_idx;
    logic [THR_W-1:0] w_scaled_sum;

    // Sum including the weight now at the head, scaled to the threshold's format.
    assign n_acm        = r_acm + TOT_W'(i_head);
    assign w_scaled_sum = {n_acm, {mcls_pkg::UNI_BITS{1'b0}}};

    // The final entry always satisfies the compare; the index check is a backstop.
    assign o_hit  = (w_scaled_sum >= i_threshold) || (r_idx == i_last_idx);
    assign o_pick = CHOSEN_W'(r_idx) + CHOSEN_W'(1);

    // Running sum holds data only.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acm <= '0;
        end else if (i_ctl.step) begin
            r_acm <= n_acm;
        end
    end

    // Scan position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctl.start) begin
            r_idx <= '0;
        end else if (i_ctl.step) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

endmodule

>>> design/masked_categorical_label_sampler.sv
// ----------------------------------------------------------------------------
// masked_categorical_label_sampler
// An ordinary category is taken at one transfer per cycle. After the last
// transfer of a row, S_NOISE stores the scaled noise weight, S_THR forms the
// threshold, then the chain shifts one weight a cycle into the scan
// accumulator; o_valid is registered from the hit. The input is ready again
// from the cycle in which o_valid rises; a result still held by the sink
// delays the end of the scan. Reset is synchronous; the weight chain is not
// cleared, only state, count, total, o_valid, scan index and config register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module masked_categorical_label_sampler #(
    parameter int MAX_CATEGORIES = 16,
    parameter int WEIGHT_BITS    = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // Configuration
    input  logic                                          i_cfg_we,
    input  logic [mcls_pkg::INV_BITS-1:0]                 i_cfg_wdata,
    // Input channel
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [WEIGHT_BITS-1:0]                        i_weight,
    input  logic [mcls_pkg::LABEL_BITS-1:0]               i_label,
    input  logic [mcls_pkg::LABEL_BITS-1:0]               i_observed,
    input  logic [mcls_pkg::UNI_BITS-1:0]                 i_uniform,
    input  logic                                          i_last,
    // Output channel
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [$clog2(MAX_CATEGORIES+1)-1:0]           o_chosen
);

    localparam int CNT_W    = $clog2(MAX_CATEGORIES);
    localparam int CHOSEN_W = $clog2(MAX_CATEGORIES + 1);
    localparam int TOT_W    = WEIGHT_BITS + $clog2(MAX_CATEGORIES);
    localparam int THR_W    = TOT_W + mcls_pkg::UNI_BITS;
    localparam int PROD_W   = WEIGHT_BITS + mcls_pkg::INV_BITS;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CATEGORIES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_NOISE = 2'd1;
    localparam logic [1:0] S_THR   = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [mcls_pkg::INV_BITS-1:0]   r_inv_levels;
    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                r_last_idx;
    logic [TOT_W-1:0]                r_total;
    logic [WEIGHT_BITS-1:0]          r_noise;
    logic [mcls_pkg::UNI_BITS-1:0]   r_uni;
    logic [THR_W-1:0]                r_thr;
    logic                            r_out_valid;
    logic [CHOSEN_W-1:0]             r_chosen;

    logic                            w_accept;
    logic                            w_slot_free;
    logic [mcls_pkg::INV_BITS-1:0]   w_inv_sat;
    logic [PROD_W-1:0]               w_prod;
    logic [WEIGHT_BITS-1:0]          w_kept;
    logic                            w_store;
    logic                            w_hit;
    logic [CHOSEN_W-1:0]             w_pick;
    logic                            w_finish;
    mcls_pkg::t_cell_ctl             w_cell_ctl;
    mcls_pkg::t_scan_ctl             w_scan_ctl;
    logic [WEIGHT_BITS-1:0]          w_wr_data;
    logic [WEIGHT_BITS-1:0]          w_cell_q [MAX_CATEGORIES];

    // Handshake and datapath helpers.
    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;
    assign w_kept      = (i_label == i_observed) ? i_weight : '0;
    assign w_store     = w_accept && !i_last && (r_count < CNT_LIMIT);
    assign w_inv_sat   = r_inv_levels[mcls_pkg::INV_BITS-1] ? mcls_pkg::INV_ONE
                                                            : r_inv_levels;
    assign w_prod      = PROD_W'(i_weight) * PROD_W'(w_inv_sat);
    assign w_finish    = (r_state == S_SCAN) && w_hit && w_slot_free;

    // Cell and scan control.
    always_comb begin
        w_cell_ctl.load  = w_store || (r_state == S_NOISE);
        w_cell_ctl.shift = (r_state == S_SCAN) && !w_hit;
        w_wr_data        = (r_state == S_NOISE) ? r_noise : w_kept;
        w_scan_ctl.start = (r_state == S_THR);
        w_scan_ctl.step  = (r_state == S_SCAN) && !w_hit;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_last) begin
                    n_state = S_NOISE;
                end
            end
            S_NOISE: begin
                n_state = S_THR;
            end
            S_THR: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_inv_levels <= mcls_pkg::INV_ONE;
            r_count      <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_inv_levels <= i_cfg_wdata;
            end
            if (w_store) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= r_total + TOT_W'(w_kept);
            end else if (r_state == S_NOISE) begin
                r_total <= r_total + TOT_W'(r_noise);
            end else if (r_state == S_THR) begin
                r_count <= '0;
                r_total <= '0;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the row end.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_last) begin
            r_noise <= w_prod[WEIGHT_BITS+15:16];
            r_uni   <= i_uniform;
        end
        if (r_state == S_NOISE) begin
            r_last_idx <= r_count;
        end
        if (r_state == S_THR) begin
            r_thr <= THR_W'(r_uni) * THR_W'(r_total);
        end
        if (w_finish) begin
            r_chosen <= w_pick;
        end
    end

    // Storage chain; the tail takes zero as it shifts towards the head.
    for (genvar g = 0; g < MAX_CATEGORIES; g++) begin : g_cell
        logic [WEIGHT_BITS-1:0] w_nb;
        if (g == MAX_CATEGORIES - 1) begin : g_tail
            assign w_nb = '0;
        end else begin : g_link
            assign w_nb = w_cell_q[g+1];
        end
        mcls_cell #(
            .WEIGHT_BITS (WEIGHT_BITS),
            .CNT_W       (CNT_W),
            .IDX         (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_cell_ctl),
            .i_wr_idx  (r_count),
            .i_wr_data (w_wr_data),
            .i_nb_data (w_nb),
            .o_data    (w_cell_q[g])
        );
    end

    // Scan accumulator at the head of the chain.
    mcls_scan #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .TOT_W       (TOT_W),
        .CNT_W       (CNT_W),
        .CHOSEN_W    (CHOSEN_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_scan_ctl),
        .i_head      (w_cell_q[0]),
        .i_threshold (r_thr),
        .i_last_idx  (r_last_idx),
        .o_hit       (w_hit),
        .o_pick      (w_pick)
    );

    assign o_valid  = r_out_valid;
    assign o_chosen = r_chosen;

    // Checks.
    `ASSERT_CLKD(a_last_starts_noise, i_clk, i_rst_n,
        (w_accept && i_last) |=> (r_state == S_NOISE))
    `ASSERT_CLKD(a_noise_then_thr, i_clk, i_rst_n,
        (r_state == S_NOISE) |=> (r_state == S_THR))
    `ASSERT_CLKD(a_count_bound, i_clk, i_rst_n,
        r_count <= CNT_LIMIT)
    `ASSERT_CLKD(a_result_from_scan, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == S_SCAN))

endmodule
